// File: rtl/tlcc_pkg.sv
// shared types, codes and constants of the two-length combination counter
package tlcc_pkg;

    // most solution lines sent for one request
    localparam int MAX_LISTED = 63;
    localparam int K_W        = $clog2(MAX_LISTED + 1);
    localparam int PC_W       = 5;

    // result kinds
    typedef enum logic [1:0] {
        KIND_SOL   = 2'd0,
        KIND_TOTAL = 2'd1,
        KIND_NONE  = 2'd2,
        KIND_BAD   = 2'd3
    } t_kind;

    // input request payload
    typedef struct packed {
        logic [31:0] distance;
        logic        operation;
    } t_req;

    // result payload
    typedef struct packed {
        t_kind       kind;
        logic [31:0] pieces_a;
        logic [31:0] pieces_b;
        logic [32:0] total_count;
        logic        list_truncated;
        logic        last;
    } t_res;

    // micro-operations of the datapath
    typedef enum logic [4:0] {
        OP_NOP      = 5'd0,
        OP_ACCEPT   = 5'd1,
        OP_DIV_AB   = 5'd2,
        OP_DIV_EUC  = 5'd3,
        OP_MUL_EUC  = 5'd4,
        OP_BEZOUT   = 5'd5,
        OP_GCD      = 5'd6,
        OP_DIV_BG   = 5'd7,
        OP_INV      = 5'd8,
        OP_DIV_AG   = 5'd9,
        OP_DIV_DG   = 5'd10,
        OP_DIV_DA   = 5'd11,
        OP_DIV_DRS  = 5'd12,
        OP_MUL_I0   = 5'd13,
        OP_DIV_I0   = 5'd14,
        OP_DIV_TOP  = 5'd15,
        OP_MUL_TA   = 5'd16,
        OP_DIV_C    = 5'd17,
        OP_CLR_K    = 5'd18,
        OP_EMIT_SOL = 5'd19,
        OP_EMIT_SUM = 5'd20,
        OP_ZERO     = 5'd21,
        OP_EMIT_BAD = 5'd22
    } t_uop;

    // jump conditions of a control word
    typedef enum logic [2:0] {
        C_NEXT     = 3'd0,
        C_ALWAYS   = 3'd1,
        C_BAD_LEN  = 3'd2,
        C_NR_ZERO  = 3'd3,
        C_REM_NZ   = 3'd4,
        C_IMAX_LT  = 3'd5,
        C_NOT_LIST = 3'd6,
        C_LIST_END = 3'd7
    } t_cond;

    // one control word of the program
    typedef struct packed {
        t_uop             op;
        t_cond            cond;
        logic [PC_W-1:0]  tgt;
    } t_uword;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic op_done;
        logic bad_len;
        logic nr_zero;
        logic rem_nz;
        logic imax_lt;
        logic not_list;
        logic list_end;
    } t_stat;

    // divider start request
    typedef struct packed {
        logic        start;
        logic        half;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } t_div_req;

endpackage

// File: rtl/tlcc_div.sv
// restoring divider, one quotient bit per cycle, 32 or 16 bit dividend
module tlcc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tlcc_pkg::t_div_req i_req,
    output logic              o_done,
    output logic [31:0]       o_quo,
    output logic [15:0]       o_rem
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_quo;
    logic [15:0] r_rem;
    logic [15:0] r_dsr;
    logic [16:0] shifted;
    logic [16:0] diff;
    logic        ge;

    // one trial subtraction
    always_comb begin
        shifted = {r_rem, r_quo[31]};
        diff    = shifted - {1'b0, r_dsr};
        ge      = (shifted >= {1'b0, r_dsr});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // done pulses for one cycle after the last quotient bit
            r_done <= !i_req.start && r_busy && (r_cnt == 5'd0);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.half ? 5'd15 : 5'd31;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // operands and partial results
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.half ? {i_req.dividend[15:0], 16'd0} : i_req.dividend;
            r_rem <= '0;
            r_dsr <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[30:0], ge};
            r_rem <= ge ? diff[15:0] : shifted[15:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// File: rtl/tlcc_seq.sv
// microprogram sequencer: step counter, control store and jumps
module tlcc_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tlcc_pkg::t_stat i_stat,
    output tlcc_pkg::t_uop  o_op
);

    logic [tlcc_pkg::PC_W-1:0] r_pc;
    logic [tlcc_pkg::PC_W-1:0] n_pc;
    tlcc_pkg::t_uword          uw;
    logic                      take;

    // control store
    always_comb begin
        case (r_pc)
            5'd0:    uw = '{tlcc_pkg::OP_ACCEPT,   tlcc_pkg::C_NEXT,     5'd0};
            5'd1:    uw = '{tlcc_pkg::OP_NOP,      tlcc_pkg::C_BAD_LEN,  5'd26};
            5'd2:    uw = '{tlcc_pkg::OP_DIV_AB,   tlcc_pkg::C_NEXT,     5'd0};
            5'd3:    uw = '{tlcc_pkg::OP_NOP,      tlcc_pkg::C_NR_ZERO,  5'd7};
            5'd4:    uw = '{tlcc_pkg::OP_DIV_EUC,  tlcc_pkg::C_NEXT,     5'd0};
            5'd5:    uw = '{tlcc_pkg::OP_MUL_EUC,  tlcc_pkg::C_NEXT,     5'd0};
            5'd6:    uw = '{tlcc_pkg::OP_BEZOUT,   tlcc_pkg::C_ALWAYS,   5'd3};
            5'd7:    uw = '{tlcc_pkg::OP_GCD,      tlcc_pkg::C_NEXT,     5'd0};
            5'd8:    uw = '{tlcc_pkg::OP_DIV_BG,   tlcc_pkg::C_NEXT,     5'd0};
            5'd9:    uw = '{tlcc_pkg::OP_INV,      tlcc_pkg::C_NEXT,     5'd0};
            5'd10:   uw = '{tlcc_pkg::OP_DIV_AG,   tlcc_pkg::C_NEXT,     5'd0};
            5'd11:   uw = '{tlcc_pkg::OP_DIV_DG,   tlcc_pkg::C_NEXT,     5'd0};
            5'd12:   uw = '{tlcc_pkg::OP_NOP,      tlcc_pkg::C_REM_NZ,   5'd25};
            5'd13:   uw = '{tlcc_pkg::OP_DIV_DA,   tlcc_pkg::C_NEXT,     5'd0};
            5'd14:   uw = '{tlcc_pkg::OP_DIV_DRS,  tlcc_pkg::C_NEXT,     5'd0};
            5'd15:   uw = '{tlcc_pkg::OP_MUL_I0,   tlcc_pkg::C_NEXT,     5'd0};
            5'd16:   uw = '{tlcc_pkg::OP_DIV_I0,   tlcc_pkg::C_NEXT,     5'd0};
            5'd17:   uw = '{tlcc_pkg::OP_NOP,      tlcc_pkg::C_IMAX_LT,  5'd25};
            5'd18:   uw = '{tlcc_pkg::OP_DIV_TOP,  tlcc_pkg::C_NEXT,     5'd0};
            5'd19:   uw = '{tlcc_pkg::OP_MUL_TA,   tlcc_pkg::C_NEXT,     5'd0};
            5'd20:   uw = '{tlcc_pkg::OP_DIV_C,    tlcc_pkg::C_NEXT,     5'd0};
            5'd21:   uw = '{tlcc_pkg::OP_CLR_K,    tlcc_pkg::C_NOT_LIST, 5'd24};
            5'd22:   uw = '{tlcc_pkg::OP_NOP,      tlcc_pkg::C_LIST_END, 5'd24};
            5'd23:   uw = '{tlcc_pkg::OP_EMIT_SOL, tlcc_pkg::C_ALWAYS,   5'd22};
            5'd24:   uw = '{tlcc_pkg::OP_EMIT_SUM, tlcc_pkg::C_ALWAYS,   5'd0};
            5'd25:   uw = '{tlcc_pkg::OP_ZERO,     tlcc_pkg::C_ALWAYS,   5'd24};
            5'd26:   uw = '{tlcc_pkg::OP_EMIT_BAD, tlcc_pkg::C_ALWAYS,   5'd0};
            default: uw = '{tlcc_pkg::OP_NOP,      tlcc_pkg::C_ALWAYS,   5'd0};
        endcase
    end

    // jump condition
    always_comb begin
        case (uw.cond)
            tlcc_pkg::C_NEXT:     take = 1'b0;
            tlcc_pkg::C_ALWAYS:   take = 1'b1;
            tlcc_pkg::C_BAD_LEN:  take = i_stat.bad_len;
            tlcc_pkg::C_NR_ZERO:  take = i_stat.nr_zero;
            tlcc_pkg::C_REM_NZ:   take = i_stat.rem_nz;
            tlcc_pkg::C_IMAX_LT:  take = i_stat.imax_lt;
            tlcc_pkg::C_NOT_LIST: take = i_stat.not_list;
            tlcc_pkg::C_LIST_END: take = i_stat.list_end;
            default:              take = 1'b0;
        endcase
    end

    // step counter
    always_comb begin
        n_pc = r_pc;
        if (i_stat.op_done) begin
            n_pc = take ? uw.tgt : r_pc + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_op = uw.op;

endmodule

// File: rtl/tlcc_dpath.sv
// datapath: working registers, shared divider and multiplier, output register
module tlcc_dpath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tlcc_pkg::t_uop  i_op,
    input  logic [15:0]     i_len_a,
    input  logic [15:0]     i_len_b,
    input  logic            i_in_valid,
    input  tlcc_pkg::t_req  i_in_req,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output tlcc_pkg::t_res  o_out_res,
    output tlcc_pkg::t_stat o_stat
);

    // request and working registers
    logic [31:0]              r_d;
    logic                     r_list;
    logic [15:0]              r_x;
    logic [15:0]              r_nr;
    logic [15:0]              r_q16;
    logic signed [17:0]       r_t;
    logic signed [17:0]       r_nt;
    logic [15:0]              r_g;
    logic [15:0]              r_step;
    logic [15:0]              r_inv;
    logic [15:0]              r_ar;
    logic [31:0]              r_dr;
    logic [15:0]              r_rem;
    logic [31:0]              r_imax;
    logic [15:0]              r_i0;
    logic [31:0]              r_i;
    logic [31:0]              r_c;
    logic [32:0]              r_cnt;
    logic [tlcc_pkg::K_W-1:0] r_k;
    logic [31:0]              r_prod;
    logic                     r_div_run;
    logic                     r_out_valid;
    tlcc_pkg::t_res           r_out;
    tlcc_pkg::t_res           n_out;

    logic                     is_div;
    logic                     is_mul;
    logic                     is_emit;
    logic                     out_free;
    logic                     div_done;
    logic [31:0]              div_quo;
    logic [15:0]              div_rem;
    tlcc_pkg::t_div_req       div_req;
    logic signed [32:0]       mul_a;
    logic signed [17:0]       mul_b;
    logic signed [50:0]       mul_p;
    logic [17:0]              inv_sum;
    logic                     trunc;
    logic                     op_done;

    // operation classes
    always_comb begin
        is_div = 1'b0;
        is_mul = 1'b0;
        is_emit = 1'b0;
        case (i_op)
            tlcc_pkg::OP_DIV_AB, tlcc_pkg::OP_DIV_EUC, tlcc_pkg::OP_DIV_BG,
            tlcc_pkg::OP_DIV_AG, tlcc_pkg::OP_DIV_DG, tlcc_pkg::OP_DIV_DA,
            tlcc_pkg::OP_DIV_DRS, tlcc_pkg::OP_DIV_I0, tlcc_pkg::OP_DIV_TOP,
            tlcc_pkg::OP_DIV_C: begin
                is_div = 1'b1;
            end
            tlcc_pkg::OP_MUL_EUC, tlcc_pkg::OP_MUL_I0, tlcc_pkg::OP_MUL_TA: begin
                is_mul = 1'b1;
            end
            tlcc_pkg::OP_EMIT_SOL, tlcc_pkg::OP_EMIT_SUM, tlcc_pkg::OP_EMIT_BAD: begin
                is_emit = 1'b1;
            end
            default: begin
                is_div = 1'b0;
            end
        endcase
    end

    // divider operand select
    always_comb begin
        div_req.start    = is_div && !r_div_run;
        div_req.half     = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = i_len_b;
        case (i_op)
            tlcc_pkg::OP_DIV_AB: begin
                div_req.half     = 1'b1;
                div_req.dividend = {16'd0, i_len_a};
                div_req.divisor  = i_len_b;
            end
            tlcc_pkg::OP_DIV_EUC: begin
                div_req.half     = 1'b1;
                div_req.dividend = {16'd0, r_x};
                div_req.divisor  = r_nr;
            end
            tlcc_pkg::OP_DIV_BG: begin
                div_req.half     = 1'b1;
                div_req.dividend = {16'd0, i_len_b};
                div_req.divisor  = r_g;
            end
            tlcc_pkg::OP_DIV_AG: begin
                div_req.half     = 1'b1;
                div_req.dividend = {16'd0, i_len_a};
                div_req.divisor  = r_g;
            end
            tlcc_pkg::OP_DIV_DG: begin
                div_req.dividend = r_d;
                div_req.divisor  = r_g;
            end
            tlcc_pkg::OP_DIV_DA: begin
                div_req.dividend = r_d;
                div_req.divisor  = i_len_a;
            end
            tlcc_pkg::OP_DIV_DRS: begin
                div_req.dividend = r_dr;
                div_req.divisor  = r_step;
            end
            tlcc_pkg::OP_DIV_I0: begin
                div_req.dividend = r_prod;
                div_req.divisor  = r_step;
            end
            tlcc_pkg::OP_DIV_TOP: begin
                div_req.dividend = r_imax - {16'd0, r_i0};
                div_req.divisor  = r_step;
            end
            tlcc_pkg::OP_DIV_C: begin
                div_req.dividend = r_d - r_prod;
                div_req.divisor  = i_len_b;
            end
            default: begin
                div_req.half = 1'b0;
            end
        endcase
    end

    tlcc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_op)
            tlcc_pkg::OP_MUL_EUC: begin
                mul_a = {17'd0, r_q16};
                mul_b = r_nt;
            end
            tlcc_pkg::OP_MUL_I0: begin
                mul_a = {17'd0, r_rem};
                mul_b = {2'd0, r_inv};
            end
            tlcc_pkg::OP_MUL_TA: begin
                mul_a = {1'b0, r_i};
                mul_b = {2'd0, i_len_a};
            end
            default: begin
                mul_a = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // handshake and completion
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (i_op == tlcc_pkg::OP_ACCEPT);
    assign inv_sum    = r_t + {2'd0, r_step};
    assign trunc      = r_list && (r_cnt > 33'(tlcc_pkg::MAX_LISTED));

    always_comb begin
        if (i_op == tlcc_pkg::OP_ACCEPT) begin
            op_done = i_in_valid;
        end else if (is_div) begin
            op_done = div_done;
        end else if (is_emit) begin
            op_done = out_free;
        end else begin
            op_done = 1'b1;
        end
    end

    // status for the sequencer
    always_comb begin
        o_stat.op_done  = op_done;
        o_stat.bad_len  = (i_len_a == 16'd0) || (i_len_b == 16'd0) || (i_len_a == i_len_b);
        o_stat.nr_zero  = (r_nr == 16'd0);
        o_stat.rem_nz   = (r_rem != 16'd0);
        o_stat.imax_lt  = (r_imax < {16'd0, r_i0});
        o_stat.not_list = !r_list;
        o_stat.list_end = ({27'd0, r_k} >= r_cnt) || (r_k == tlcc_pkg::K_W'(tlcc_pkg::MAX_LISTED));
    end

    // divider busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_run <= 1'b0;
        end else if (div_req.start) begin
            r_div_run <= 1'b1;
        end else if (div_done) begin
            r_div_run <= 1'b0;
        end
    end

    // working register updates
    always_ff @(posedge i_clk) begin
        if (is_mul) begin
            r_prod <= mul_p[31:0];
        end
        case (i_op)
            tlcc_pkg::OP_ACCEPT: begin
                r_d    <= i_in_req.distance;
                r_list <= i_in_req.operation;
            end
            tlcc_pkg::OP_DIV_AB: begin
                if (div_done) begin
                    r_x  <= i_len_b;
                    r_nr <= div_rem;
                    r_t  <= 18'sd0;
                    r_nt <= 18'sd1;
                end
            end
            tlcc_pkg::OP_DIV_EUC: begin
                if (div_done) begin
                    r_q16 <= div_quo[15:0];
                    r_x   <= r_nr;
                    r_nr  <= div_rem;
                end
            end
            tlcc_pkg::OP_BEZOUT: begin
                r_t  <= r_nt;
                r_nt <= r_t - signed'(r_prod[17:0]);
            end
            tlcc_pkg::OP_GCD: begin
                r_g <= r_x;
            end
            tlcc_pkg::OP_DIV_BG: begin
                if (div_done) begin
                    r_step <= div_quo[15:0];
                end
            end
            tlcc_pkg::OP_INV: begin
                r_inv <= r_t[17] ? inv_sum[15:0] : r_t[15:0];
            end
            tlcc_pkg::OP_DIV_AG: begin
                if (div_done) begin
                    r_ar <= div_quo[15:0];
                end
            end
            tlcc_pkg::OP_DIV_DG: begin
                if (div_done) begin
                    r_dr  <= div_quo;
                    r_rem <= div_rem;
                end
            end
            tlcc_pkg::OP_DIV_DA: begin
                if (div_done) begin
                    r_imax <= div_quo;
                end
            end
            tlcc_pkg::OP_DIV_DRS: begin
                if (div_done) begin
                    r_rem <= div_rem;
                end
            end
            tlcc_pkg::OP_DIV_I0: begin
                if (div_done) begin
                    r_i0 <= div_rem;
                end
            end
            tlcc_pkg::OP_DIV_TOP: begin
                if (div_done) begin
                    r_cnt <= {1'b0, div_quo} + 33'd1;
                    r_i   <= r_imax - {16'd0, div_rem};
                end
            end
            tlcc_pkg::OP_DIV_C: begin
                if (div_done) begin
                    r_c <= div_quo;
                end
            end
            tlcc_pkg::OP_CLR_K: begin
                r_k <= '0;
            end
            tlcc_pkg::OP_EMIT_SOL: begin
                if (out_free) begin
                    if (r_i >= {16'd0, r_step}) begin
                        r_i <= r_i - {16'd0, r_step};
                    end
                    r_c <= r_c + {16'd0, r_ar};
                    r_k <= r_k + tlcc_pkg::K_W'(1);
                end
            end
            tlcc_pkg::OP_ZERO: begin
                r_cnt <= '0;
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (is_emit && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // next result payload
    always_comb begin
        n_out = '0;
        case (i_op)
            tlcc_pkg::OP_EMIT_SOL: begin
                n_out.kind     = tlcc_pkg::KIND_SOL;
                n_out.pieces_a = r_i;
                n_out.pieces_b = r_c;
            end
            tlcc_pkg::OP_EMIT_SUM: begin
                n_out.last = 1'b1;
                if (r_cnt == 33'd0) begin
                    n_out.kind = tlcc_pkg::KIND_NONE;
                end else begin
                    n_out.kind           = tlcc_pkg::KIND_TOTAL;
                    n_out.total_count    = r_cnt;
                    n_out.list_truncated = trunc;
                end
            end
            default: begin
                n_out.kind = tlcc_pkg::KIND_BAD;
                n_out.last = 1'b1;
            end
        endcase
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (is_emit && out_free) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

endmodule

// File: rtl/two_length_combination_counter.sv
// top level: configuration port, sequencer and datapath of the combination counter
//
//  channel   signals                                    moves
//  -------   -----------------------------------------  ---------------------------
//  in        i_in_valid / o_in_ready / i_in_req          distance, operation
//  out       o_out_valid / i_out_ready / o_out_res       kind, pieces, count, flags
//  config    psel penable pwrite paddr pwdata prdata     length_a @0, length_b @4
//
//  the shared bit-serial divider sets the time of a request, along with the number of
//  extended-gcd rounds and of listed solutions; a distance that is not a multiple of the
//  gcd or has no solution exits earlier, and invalid lengths go straight to the error
//  result without any division
//  requests are taken one at a time; a result waits in an output register so the
//  program runs on while the consumer stalls, and halts only when that register is full
//  synchronous active-low reset returns the program to its accept step, lengths to 1 and 2
module two_length_combination_counter (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  tlcc_pkg::t_req i_in_req,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output tlcc_pkg::t_res o_out_res,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    logic [15:0]     r_len_a;
    logic [15:0]     r_len_b;
    tlcc_pkg::t_uop  op;
    tlcc_pkg::t_stat stat;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_a <= 16'd1;
            r_len_b <= 16'd2;
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) begin
                r_len_b <= pwdata[15:0];
            end else begin
                r_len_a <= pwdata[15:0];
            end
        end
    end

    // register read back
    assign prdata = paddr[2] ? {16'd0, r_len_b} : {16'd0, r_len_a};
    assign pready = 1'b1;

    tlcc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_op    (op)
    );

    tlcc_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .i_len_a     (r_len_a),
        .i_len_b     (r_len_b),
        .i_in_valid  (i_in_valid),
        .i_in_req    (i_in_req),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_res   (o_out_res),
        .o_stat      (stat)
    );

endmodule
